/* rtl/klsg_pkg.sv */
// ----------------------------------------------------------------------------
// klsg_pkg: shared types and constants for the keypad lock / load gating unit
// Register map indexes, key codes, control byte bit positions, key mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package klsg_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_PASS_CHAR_0 = 3'd0,
    REG_PASS_CHAR_1 = 3'd1,
    REG_PASS_CHAR_2 = 3'd2,
    REG_PASS_CHAR_3 = 3'd3,
    REG_TEMP_LIMIT  = 3'd4,
    REG_MOIST_LIMIT = 3'd5
  } reg_index_t;

  localparam logic [7:0] PASS_CHAR_0_RST = 8'd49;
  localparam logic [7:0] PASS_CHAR_1_RST = 8'd50;
  localparam logic [7:0] PASS_CHAR_2_RST = 8'd51;
  localparam logic [7:0] PASS_CHAR_3_RST = 8'd52;
  localparam logic [9:0] LIMIT_RST       = 10'd61;

  // raw keypad positions that mean something while unlocked
  localparam logic [4:0] KEY_NONE   = 5'd0;
  localparam logic [4:0] KEY_BUZZER = 5'd1;
  localparam logic [4:0] KEY_LIGHT  = 5'd2;
  localparam logic [4:0] KEY_FAN    = 5'd3;
  localparam logic [4:0] KEY_PUMP   = 5'd5;
  localparam logic [4:0] KEY_RELOCK = 5'd15;

  localparam int unsigned BIT_WRONG    = 5;
  localparam int unsigned BIT_UNLOCKED = 7;

  localparam logic [2:0] DIGITS = 3'd4;

  // map raw key position to its ASCII legend; unmapped codes pass through
  function automatic logic [7:0] key_to_ascii(input logic [4:0] k);
    logic [7:0] a;
    case (k)
      5'd1:    a = 8'd49;
      5'd2:    a = 8'd50;
      5'd3:    a = 8'd51;
      5'd5:    a = 8'd52;
      5'd6:    a = 8'd53;
      5'd7:    a = 8'd54;
      5'd9:    a = 8'd55;
      5'd10:   a = 8'd56;
      5'd11:   a = 8'd57;
      5'd13:   a = 8'd42;
      5'd14:   a = 8'd48;
      5'd15:   a = 8'd35;
      default: a = {3'b000, k};
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/keypad_lock_sensor_gating_unit.sv */
// ----------------------------------------------------------------------------
// keypad_lock_sensor_gating_unit: keypad combination lock with gated loads
// Checks a four-key password, gates four loads by sensor and enable bits and
// lets the unlocked user toggle enables or relock.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | sink      | in_valid/in_stall  | key_code, door_open, motion_seen,
//           |           |                    | temp_sample, moist_sample
//  out      | source    | out_valid/out_stall| control_byte, enable_mask
//  cfg      | APB slave | psel/penable/pready| paddr, pwdata, prdata
//
// One word per cycle while out_stall is low: an accepted word sits in the input
// register, is resolved by one pass of compare and flag logic and lands in the
// state/result register once that register drains or is empty.
// Reset is synchronous and restores the password and limit registers.
// A stalled result holds the state; in_stall rises only when the input register
// is full and the result cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_lock_sensor_gating_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  key_code,
  input  wire logic        door_open,
  input  wire logic        motion_seen,
  input  wire logic [9:0]  temp_sample,
  input  wire logic [9:0]  moist_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       control_byte,
  output logic [3:0]       enable_mask
);

  // configuration registers
  logic [7:0] pass_char [4];
  logic [9:0] temp_limit;
  logic [9:0] moist_limit;
  logic       cfg_write;
  logic [2:0] cfg_index;

  // input register
  logic       hold_valid;
  logic [4:0] hold_key;
  logic       hold_door;
  logic       hold_motion;
  logic [9:0] hold_temp;
  logic [9:0] hold_moist;

  // lock state, also the result register
  logic [7:0] ctrl_reg;
  logic [7:0] ctrl_reg_next;
  logic [3:0] enables;
  logic [3:0] enables_next;
  logic [2:0] digit_count;
  logic [2:0] digit_count_next;
  logic [3:0] digit_ok;
  logic       digit_we;
  logic       digit_match;
  logic [3:0] loads;

  logic       out_free;
  logic       advance;
  logic       in_take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_char[0] <= klsg_pkg::PASS_CHAR_0_RST;
      pass_char[1] <= klsg_pkg::PASS_CHAR_1_RST;
      pass_char[2] <= klsg_pkg::PASS_CHAR_2_RST;
      pass_char[3] <= klsg_pkg::PASS_CHAR_3_RST;
      temp_limit   <= klsg_pkg::LIMIT_RST;
      moist_limit  <= klsg_pkg::LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        klsg_pkg::REG_PASS_CHAR_0: pass_char[0] <= pwdata[7:0];
        klsg_pkg::REG_PASS_CHAR_1: pass_char[1] <= pwdata[7:0];
        klsg_pkg::REG_PASS_CHAR_2: pass_char[2] <= pwdata[7:0];
        klsg_pkg::REG_PASS_CHAR_3: pass_char[3] <= pwdata[7:0];
        klsg_pkg::REG_TEMP_LIMIT:  temp_limit   <= pwdata[9:0];
        klsg_pkg::REG_MOIST_LIMIT: moist_limit  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      klsg_pkg::REG_PASS_CHAR_0: prdata = {24'd0, pass_char[0]};
      klsg_pkg::REG_PASS_CHAR_1: prdata = {24'd0, pass_char[1]};
      klsg_pkg::REG_PASS_CHAR_2: prdata = {24'd0, pass_char[2]};
      klsg_pkg::REG_PASS_CHAR_3: prdata = {24'd0, pass_char[3]};
      klsg_pkg::REG_TEMP_LIMIT:  prdata = {22'd0, temp_limit};
      klsg_pkg::REG_MOIST_LIMIT: prdata = {22'd0, moist_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // handshake: the result register drains or is empty, then the held word moves
  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_key    <= key_code;
      hold_door   <= door_open;
      hold_motion <= motion_seen;
      hold_temp   <= temp_sample;
      hold_moist  <= moist_sample;
    end
  end

  assign digit_match = klsg_pkg::key_to_ascii(hold_key) == pass_char[digit_count[1:0]];

  always_comb begin
    loads = {(hold_moist > moist_limit) && enables[3],
             (hold_temp  > temp_limit)  && enables[2],
             hold_motion && enables[1],
             hold_door   && enables[0]};
    ctrl_reg_next    = {ctrl_reg[7:4], loads};
    ctrl_reg_next[klsg_pkg::BIT_WRONG] = 1'b0;
    enables_next     = enables;
    digit_count_next = digit_count;
    digit_we         = 1'b0;

    if (!ctrl_reg_next[klsg_pkg::BIT_UNLOCKED]) begin
      if (digit_count < klsg_pkg::DIGITS) begin
        if (hold_key != klsg_pkg::KEY_NONE) begin
          digit_we         = 1'b1;
          digit_count_next = digit_count + 3'd1;
        end
      end else begin
        // verdict tick: key is ignored
        digit_count_next = 3'd0;
        if (&digit_ok) begin
          ctrl_reg_next[klsg_pkg::BIT_UNLOCKED] = 1'b1;
        end else begin
          ctrl_reg_next = (ctrl_reg_next & 8'h2F) | 8'h20;
        end
      end
    end else begin
      case (hold_key)
        klsg_pkg::KEY_BUZZER: enables_next[0] = !enables[0];
        klsg_pkg::KEY_LIGHT:  enables_next[1] = !enables[1];
        klsg_pkg::KEY_FAN:    enables_next[2] = !enables[2];
        klsg_pkg::KEY_PUMP:   enables_next[3] = !enables[3];
        klsg_pkg::KEY_RELOCK: begin
          enables_next     = 4'hF;
          digit_count_next = 3'd0;
          ctrl_reg_next    = 8'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_reg    <= 8'd0;
      enables     <= 4'hF;
      digit_count <= 3'd0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        ctrl_reg    <= ctrl_reg_next;
        enables     <= enables_next;
        digit_count <= digit_count_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-digit verdicts, no reset: each is written before the verdict reads it
  always_ff @(posedge clk) begin
    if (advance && digit_we) begin
      digit_ok[digit_count[1:0]] <= digit_match;
    end
  end

  assign control_byte = ctrl_reg;
  assign enable_mask  = enables;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= klsg_pkg::DIGITS)
    else $error("digit count beyond four");

  a_unlocked_no_digits: assert property (@(posedge clk) disable iff (rst)
    ctrl_reg[klsg_pkg::BIT_UNLOCKED] |-> (digit_count == 3'd0))
    else $error("digit count moved while unlocked");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(ctrl_reg) && $stable(enables)))
    else $error("lock state changed under a stalled result");
`endif

endmodule

`default_nettype wire

/* test/keypad_lock_sensor_gating_unit_tb.sv */
// ----------------------------------------------------------------------------
// keypad_lock_sensor_gating_unit_tb: self-checking bench for the lock unit
// Drives tick words through the valid/stall input, programs the password and
// limit registers over APB between phases, and checks every result word
// against a cycle-free predictor of the lock, load gating and enable toggles.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_lock_sensor_gating_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [4:0] key;
    logic       door;
    logic       motion;
    logic [9:0] temp;
    logic [9:0] moist;
  } tick_t;

  typedef struct packed {
    logic [7:0] ctrl;
    logic [3:0] en;
  } lock_word_t;

  class lock_scoreboard;
    logic [7:0] pass_code [4];
    logic [9:0] temp_lim;
    logic [9:0] moist_lim;
    logic [7:0] ctrl;
    logic [3:0] enab;
    logic [2:0] digits;
    logic [3:0] digit_hit;
    lock_word_t pending [$];
    int errors;

    function new();
      errors = 0;
      restore();
    endfunction

    function void restore();
      pass_code[0] = klsg_pkg::PASS_CHAR_0_RST;
      pass_code[1] = klsg_pkg::PASS_CHAR_1_RST;
      pass_code[2] = klsg_pkg::PASS_CHAR_2_RST;
      pass_code[3] = klsg_pkg::PASS_CHAR_3_RST;
      temp_lim = klsg_pkg::LIMIT_RST;
      moist_lim = klsg_pkg::LIMIT_RST;
      ctrl = 8'h00;
      enab = 4'hF;
      digits = 3'd0;
      digit_hit = 4'h0;
      pending.delete();
    endfunction

    // keypad legend; positions without a legend compare as their raw code
    static function logic [7:0] legend(logic [4:0] k);
      case (k)
        5'd1:    return "1";
        5'd2:    return "2";
        5'd3:    return "3";
        5'd5:    return "4";
        5'd6:    return "5";
        5'd7:    return "6";
        5'd9:    return "7";
        5'd10:   return "8";
        5'd11:   return "9";
        5'd13:   return "*";
        5'd14:   return "0";
        5'd15:   return "#";
        default: return {3'b000, k};
      endcase
    endfunction

    function void set_reg(klsg_pkg::reg_index_t idx, logic [31:0] v);
      case (idx)
        klsg_pkg::REG_PASS_CHAR_0: pass_code[0] = v[7:0];
        klsg_pkg::REG_PASS_CHAR_1: pass_code[1] = v[7:0];
        klsg_pkg::REG_PASS_CHAR_2: pass_code[2] = v[7:0];
        klsg_pkg::REG_PASS_CHAR_3: pass_code[3] = v[7:0];
        klsg_pkg::REG_TEMP_LIMIT:  temp_lim = v[9:0];
        klsg_pkg::REG_MOIST_LIMIT: moist_lim = v[9:0];
        default: ;
      endcase
    endfunction

    function void note_input(tick_t t);
      logic [3:0] loads;
      lock_word_t w;
      // gate with the enables as they stand before this tick
      loads = {(t.moist > moist_lim) && enab[3], (t.temp > temp_lim) && enab[2],
               t.motion && enab[1], t.door && enab[0]};
      ctrl = {ctrl[7:4], loads};
      ctrl[klsg_pkg::BIT_WRONG] = 1'b0;
      if (!ctrl[klsg_pkg::BIT_UNLOCKED]) begin
        if (digits < klsg_pkg::DIGITS) begin
          if (t.key != klsg_pkg::KEY_NONE) begin
            digit_hit[digits[1:0]] = (legend(t.key) == pass_code[digits[1:0]]);
            digits = digits + 3'd1;
          end
        end else begin
          // verdict tick: the key is dropped
          digits = 3'd0;
          if (&digit_hit) begin
            ctrl[klsg_pkg::BIT_UNLOCKED] = 1'b1;
          end else begin
            ctrl[klsg_pkg::BIT_UNLOCKED] = 1'b0;
            ctrl[6] = 1'b0;
            ctrl[4] = 1'b0;
            ctrl[klsg_pkg::BIT_WRONG] = 1'b1;
          end
        end
      end else begin
        case (t.key)
          klsg_pkg::KEY_BUZZER: enab[0] = ~enab[0];
          klsg_pkg::KEY_LIGHT:  enab[1] = ~enab[1];
          klsg_pkg::KEY_FAN:    enab[2] = ~enab[2];
          klsg_pkg::KEY_PUMP:   enab[3] = ~enab[3];
          klsg_pkg::KEY_RELOCK: begin
            enab = 4'hF;
            digits = 3'd0;
            ctrl = 8'h00;
          end
          default: ;
        endcase
      end
      w.ctrl = ctrl;
      w.en = enab;
      pending.push_back(w);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [7:0] cb, logic [3:0] em);
      lock_word_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result word", {20'd0, cb, em}, 32'd0);
        return;
      end
      w = pending.pop_front();
      if (cb !== w.ctrl) report_mismatch("control_byte", {24'd0, cb}, {24'd0, w.ctrl});
      if (em !== w.en) report_mismatch("enable_mask", {28'd0, em}, {28'd0, w.en});
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  key_code = '0;
  logic        door_open = 1'b0;
  logic        motion_seen = 1'b0;
  logic [9:0]  temp_sample = '0;
  logic [9:0]  moist_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  control_byte;
  logic [3:0]  enable_mask;

  lock_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int unsigned cycles = 0;

  keypad_lock_sensor_gating_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_code     (key_code),
    .door_open    (door_open),
    .motion_seen  (motion_seen),
    .temp_sample  (temp_sample),
    .moist_sample (moist_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .control_byte (control_byte),
    .enable_mask  (enable_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keypad_lock_sensor_gating_unit_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    tick_t seen;
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) begin
        seen.key = key_code;
        seen.door = door_open;
        seen.motion = motion_seen;
        seen.temp = temp_sample;
        seen.moist = moist_sample;
        sb.note_input(seen);
      end
      if (out_valid === 1'b1 && !out_stall) sb.check_result(control_byte, enable_mask);
    end
  end

  function automatic tick_t mk(logic [4:0] k, logic d, logic m, logic [9:0] t,
                               logic [9:0] w);
    tick_t r;
    r.key = k;
    r.door = d;
    r.motion = m;
    r.temp = t;
    r.moist = w;
    return r;
  endfunction

  // key position whose legend matches the code, random when none does
  function automatic logic [4:0] key_for(logic [7:0] code);
    for (int i = 1; i < 32; i++) begin
      if (lock_scoreboard::legend(5'(i)) == code) return 5'(i);
    end
    return 5'($urandom_range(1, 31));
  endfunction

  function automatic logic [9:0] near_limit(logic [9:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  function automatic logic [4:0] any_key();
    if ($urandom_range(19) == 0) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(16));
  endfunction

  function automatic tick_t make_tick();
    tick_t t;
    int r;
    t.door = 1'($urandom_range(1));
    t.motion = 1'($urandom_range(1));
    t.temp = ($urandom_range(9) < 3) ? near_limit(sb.temp_lim) : 10'($urandom_range(1023));
    t.moist = ($urandom_range(9) < 3) ? near_limit(sb.moist_lim) : 10'($urandom_range(1023));
    r = $urandom_range(99);
    if (!sb.ctrl[klsg_pkg::BIT_UNLOCKED]) begin
      if (sb.digits >= klsg_pkg::DIGITS) t.key = any_key();
      else if (r < 20) t.key = klsg_pkg::KEY_NONE;
      else if (r < 88) t.key = key_for(sb.pass_code[sb.digits[1:0]]);
      else t.key = any_key();
    end else begin
      case (r % 8)
        0:       t.key = ($urandom_range(2) == 0) ? klsg_pkg::KEY_RELOCK
                                                  : klsg_pkg::KEY_NONE;
        1:       t.key = klsg_pkg::KEY_BUZZER;
        2:       t.key = klsg_pkg::KEY_LIGHT;
        3:       t.key = klsg_pkg::KEY_FAN;
        4:       t.key = klsg_pkg::KEY_PUMP;
        5:       t.key = klsg_pkg::KEY_NONE;
        default: t.key = any_key();
      endcase
    end
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task send_tick(tick_t t);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    key_code <= t.key;
    door_open <= t.door;
    motion_seen <= t.motion;
    temp_sample <= t.temp;
    moist_sample <= t.moist;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // drop valid and hold until every expected word is back
  task drain_words(bit settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    if (settle) repeat (4) @(negedge clk);
  endtask

  task apb_write(klsg_pkg::reg_index_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task run_directed();
    logic [4:0] k0, k1, k2, k3;
    k0 = key_for(klsg_pkg::PASS_CHAR_0_RST);
    k1 = key_for(klsg_pkg::PASS_CHAR_1_RST);
    k2 = key_for(klsg_pkg::PASS_CHAR_2_RST);
    k3 = key_for(klsg_pkg::PASS_CHAR_3_RST);
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b0, 1'b0, 10'd0, 10'd0));
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b1, 1'b0, 10'd61, 10'd62));
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b0, 1'b1, 10'd62, 10'd61));
    // unmapped and out-of-range codes and the star key, then a verdict with a key
    send_tick(mk(5'd4, 1'b1, 1'b1, 10'd100, 10'd0));
    send_tick(mk(5'd16, 1'b0, 1'b1, 10'd0, 10'd100));
    send_tick(mk(5'd31, 1'b1, 1'b0, 10'd512, 10'd512));
    send_tick(mk(5'd13, 1'b0, 1'b0, 10'd1023, 10'd0));
    send_tick(mk(5'd7, 1'b1, 1'b1, 10'd0, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b0, 1'b0, 10'd0, 10'd0));
    send_tick(mk(k0, 1'b1, 1'b0, 10'd70, 10'd70));
    send_tick(mk(klsg_pkg::KEY_NONE, 1'b0, 1'b0, 10'd0, 10'd0));
    send_tick(mk(k1, 1'b0, 1'b1, 10'd0, 10'd0));
    send_tick(mk(k2, 1'b0, 1'b0, 10'd0, 10'd0));
    send_tick(mk(k3, 1'b0, 1'b0, 10'd0, 10'd0));
    send_tick(mk(5'd9, 1'b1, 1'b1, 10'd1023, 10'd1023));
    // unlocked: toggle every enable with all sensors active
    send_tick(mk(klsg_pkg::KEY_BUZZER, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_LIGHT, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_FAN, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_PUMP, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(5'd4, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(5'd14, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_BUZZER, 1'b1, 1'b1, 10'd1023, 10'd1023));
    send_tick(mk(klsg_pkg::KEY_RELOCK, 1'b1, 1'b1, 10'd1023, 10'd1023));
  endtask

  initial begin
    int n;
    logic [7:0] code;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    drain_words(1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      for (int i = 0; i < 4; i++) begin
        if (ph == 0) code = 8'h00;
        else if (ph == 1) code = 8'hFF;
        else code = lock_scoreboard::legend(5'($urandom_range(1, 31)));
        apb_write(klsg_pkg::reg_index_t'(i), {24'd0, code});
      end
      apb_write(klsg_pkg::REG_TEMP_LIMIT, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd1023
                                          : 32'($urandom_range(1023)));
      apb_write(klsg_pkg::REG_MOIST_LIMIT, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd1023
                                           : 32'($urandom_range(1023)));
      n = (ph < 2) ? 100 : 150;
      repeat (n) begin
        if ($urandom_range(49) == 0) drain_words(1'b0);
        send_tick(make_tick());
      end
      drain_words(1'b1);
    end

    if (sb.errors == 0) begin
      $display("keypad_lock_sensor_gating_unit_tb OK");
    end else begin
      $display("keypad_lock_sensor_gating_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/klsg_pkg.sv
rtl/keypad_lock_sensor_gating_unit.sv
test/keypad_lock_sensor_gating_unit_tb.sv
